// File: src/nqte_pkg.sv
package nqte_pkg;

   // Part kinds
   localparam logic [2:0] KIND_IRI   = 3'd0;
   localparam logic [2:0] KIND_BLANK = 3'd1;
   localparam logic [2:0] KIND_LIT   = 3'd2;
   localparam logic [2:0] KIND_LANG  = 3'd3;
   localparam logic [2:0] KIND_DTYPE = 3'd4;

   // ASCII characters used for framing and escapes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;  // 'A' - 10

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic [2:0] part_kind;
      logic       part_first;
      logic       part_last;
      logic       term_last;
      logic       statement_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   function automatic logic iri_needs_escape(input logic [7:0] b);
      logic r;
      begin
         r = 1'b0;
         if (b <= CH_SPACE) begin
            r = 1'b1;
         end
         case (b) inside
            CH_LT, CH_GT, CH_QUOTE, CH_LBRACE, CH_RBRACE,
            CH_PIPE, CH_CARET, CH_BTICK, CH_BSLASH: r = 1'b1;
            default: ;
         endcase
         return r;
      end
   endfunction

   // Second byte of a literal escape, zero when the byte passes unchanged
   function automatic logic [7:0] lit_escape(input logic [7:0] b);
      logic [7:0] r;
      begin
         case (b)
            CH_TAB:    r = CH_LOW_T;
            CH_BS:     r = CH_LOW_B;
            CH_LF:     r = CH_LOW_N;
            CH_CR:     r = CH_LOW_R;
            CH_FF:     r = CH_LOW_F;
            CH_QUOTE:  r = CH_QUOTE;
            CH_BSLASH: r = CH_BSLASH;
            default:   r = 8'h00;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      begin
         if (v < 4'd10) begin
            r = CH_ZERO + {4'h0, v};
         end else begin
            r = HEX_ALPHA_BASE + {4'h0, v};
         end
         return r;
      end
   endfunction

endpackage

// File: src/nquads_term_escaper.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_payload_type (one raw byte + flags)
// rsp     | out       | rsp_valid / rsp_ready | rsp_payload_type (one text byte)
//
// An item stays in the item register until its last byte enters the output
// register, and the next item enters in that cycle; one-byte items flow at one
// per cycle while rsp is not stalled. An item with nothing to emit skips the
// output register. Synchronous active-high reset clears both valid flags and the
// byte index. A stalled rsp holds the output register and the item behind it.
module nquads_term_escaper
   import nqte_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // Item register: the item being expanded and the index of its next byte
   req_payload_type item_ff;
   logic            item_valid_ff, item_valid_in;
   logic [3:0]      idx_ff, idx_in;

   // Output register
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Segment lengths and end offsets of the expansion
   logic       is_iri, is_lit, iri_esc, lit_esc;
   logic [7:0] lit_code;
   logic [3:0] open_len, body_len, close_len, space_len, stmt_len;
   logic [3:0] end_open, end_body, end_close, end_space, total;
   logic [3:0] local_idx;
   logic [7:0] cur_byte;
   logic       cur_last, out_load, item_done;

   always_comb begin
      is_iri   = (item_ff.part_kind == KIND_IRI) || (item_ff.part_kind == KIND_DTYPE);
      is_lit   = (item_ff.part_kind == KIND_LIT);
      lit_code = lit_escape(item_ff.data_byte);
      iri_esc  = is_iri && iri_needs_escape(item_ff.data_byte);
      lit_esc  = is_lit && (lit_code != 8'h00);

      // opener length
      open_len = 4'd0;
      if (item_ff.part_first) begin
         unique case (item_ff.part_kind)
            KIND_IRI:   open_len = 4'd1;
            KIND_BLANK: open_len = 4'd2;
            KIND_LIT:   open_len = 4'd1;
            KIND_LANG:  open_len = 4'd1;
            KIND_DTYPE: open_len = 4'd3;
            default:    open_len = 4'd0;
         endcase
      end

      body_len = 4'd0;
      if (item_ff.has_byte) begin
         if (iri_esc) begin
            body_len = 4'd6;
         end else if (lit_esc) begin
            body_len = 4'd2;
         end else begin
            body_len = 4'd1;
         end
      end

      close_len = (item_ff.part_last && (is_iri || is_lit)) ? 4'd1 : 4'd0;
      space_len = item_ff.term_last ? 4'd1 : 4'd0;
      stmt_len  = item_ff.statement_last ? 4'd2 : 4'd0;

      end_open  = open_len;
      end_body  = end_open + body_len;
      end_close = end_body + close_len;
      end_space = end_close + space_len;
      total     = end_space + stmt_len;

      // pick the byte at the current index by segment
      local_idx = 4'd0;
      cur_byte  = 8'h00;
      if (idx_ff < end_open) begin
         local_idx = idx_ff;
         unique case (item_ff.part_kind)
            KIND_IRI:   cur_byte = CH_LT;
            KIND_BLANK: cur_byte = (local_idx == 4'd0) ? CH_UNDER : CH_COLON;
            KIND_LIT:   cur_byte = CH_QUOTE;
            KIND_LANG:  cur_byte = CH_AT;
            KIND_DTYPE: cur_byte = (local_idx < 4'd2) ? CH_CARET : CH_LT;
            default:    cur_byte = 8'h00;
         endcase
      end else if (idx_ff < end_body) begin
         local_idx = idx_ff - end_open;
         if (iri_esc) begin
            case (local_idx)
               4'd0:    cur_byte = CH_BSLASH;
               4'd1:    cur_byte = CH_LOW_U;
               4'd2:    cur_byte = CH_ZERO;
               4'd3:    cur_byte = CH_ZERO;
               4'd4:    cur_byte = hex_digit(item_ff.data_byte[7:4]);
               default: cur_byte = hex_digit(item_ff.data_byte[3:0]);
            endcase
         end else if (lit_esc) begin
            cur_byte = (local_idx == 4'd0) ? CH_BSLASH : lit_code;
         end else begin
            cur_byte = item_ff.data_byte;
         end
      end else if (idx_ff < end_close) begin
         cur_byte = is_lit ? CH_QUOTE : CH_GT;
      end else if (idx_ff < end_space) begin
         cur_byte = CH_SPACE;
      end else begin
         cur_byte = (idx_ff == end_space) ? CH_DOT : CH_LF;
      end

      cur_last = (idx_ff == (total - 4'd1));
   end

   // The output register loads from a valid item with bytes to emit whenever it is empty or being drained
   assign out_load  = item_valid_ff && (total != 4'd0) && (!rsp_valid_ff || rsp_ready);
   // The item leaves on its last byte, or at once when it emits nothing
   assign item_done = item_valid_ff && ((total == 4'd0) || (out_load && cur_last));
   assign req_ready = !item_valid_ff || item_done;

   always_comb begin
      item_valid_in = item_valid_ff;
      idx_in        = idx_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         idx_in        = 4'd0;
      end else if (item_done) begin
         item_valid_in = 1'b0;
         idx_in        = 4'd0;
      end else if (out_load) begin
         idx_in = idx_ff + 4'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = cur_byte;
         rsp_in.last_of_run = cur_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
